// ===== rtl/assert_macros.svh =====
// Assertion helpers for the frame buffer. SYNTH drops every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FB_ASSERT(lbl, clk, rst_n, prop, msg)
`define FB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/tpfb_pkg.sv =====
package tpfb_pkg;

	localparam int PANEL_WIDTH = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int BANDS = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = BANDS * PANEL_WIDTH;
	localparam int MEM_AW = $clog2(STORE_BYTES);
	localparam int FIRST_CODE = 32;
	localparam int LAST_CODE = 90;
	localparam int GLYPH_COLS = 5;
	localparam int XC_W = 12;

	localparam logic signed [7:0] BANDS_S = 8'(BANDS);
	localparam logic signed [XC_W-1:0] WIDTH_S = XC_W'(PANEL_WIDTH);
	// Rows of the bottom band that lie on the panel.
	localparam logic [7:0] LAST_ROW_MASK = (PANEL_HEIGHT % 8 == 0) ? 8'hFF :
		8'((9'd1 << (PANEL_HEIGHT % 8)) - 9'd1);

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_PIXEL = 2'd1,
		REQ_CHAR  = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_WRITE,
		ST_FETCH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		req_t               op;
		logic signed [8:0]  x;
		logic signed [7:0]  y;
		logic               lit;
		logic [5:0]         sel;
		logic [9:0]         addr;
	} cmd_t;

	// Five glyph columns, leftmost in the top byte.
	function automatic logic [39:0] glyph_word(input logic [5:0] sel);
		logic [39:0] w;
		unique case (sel)
			6'd0:  w = 40'h0000000000; 6'd1:  w = 40'h00005F0000;
			6'd2:  w = 40'h0007000700; 6'd3:  w = 40'h147F147F14;
			6'd4:  w = 40'h242A7F2A12; 6'd5:  w = 40'h2313086462;
			6'd6:  w = 40'h3649552250; 6'd7:  w = 40'h0005030000;
			6'd8:  w = 40'h001C224100; 6'd9:  w = 40'h0041221C00;
			6'd10: w = 40'h082A1C2A08; 6'd11: w = 40'h08083E0808;
			6'd12: w = 40'h0050300000; 6'd13: w = 40'h0808080808;
			6'd14: w = 40'h0060600000; 6'd15: w = 40'h2010080402;
			6'd16: w = 40'h3E5149453E; 6'd17: w = 40'h00427F4000;
			6'd18: w = 40'h4261514946; 6'd19: w = 40'h2141454B31;
			6'd20: w = 40'h1814127F10; 6'd21: w = 40'h2745454539;
			6'd22: w = 40'h3C4A494930; 6'd23: w = 40'h0171090503;
			6'd24: w = 40'h3649494936; 6'd25: w = 40'h064949291E;
			6'd26: w = 40'h0036360000; 6'd27: w = 40'h0056360000;
			6'd28: w = 40'h0008142241; 6'd29: w = 40'h1414141414;
			6'd30: w = 40'h4122140800; 6'd31: w = 40'h0201510906;
			6'd32: w = 40'h324979413E; 6'd33: w = 40'h7E1111117E;
			6'd34: w = 40'h7F49494936; 6'd35: w = 40'h3E41414122;
			6'd36: w = 40'h7F4141221C; 6'd37: w = 40'h7F49494941;
			6'd38: w = 40'h7F09090101; 6'd39: w = 40'h3E41415132;
			6'd40: w = 40'h7F0808087F; 6'd41: w = 40'h00417F4100;
			6'd42: w = 40'h2040413F01; 6'd43: w = 40'h7F08142241;
			6'd44: w = 40'h7F40404040; 6'd45: w = 40'h7F0204027F;
			6'd46: w = 40'h7F0408107F; 6'd47: w = 40'h3E4141413E;
			6'd48: w = 40'h7F09090906; 6'd49: w = 40'h3E4151215E;
			6'd50: w = 40'h7F09192946; 6'd51: w = 40'h4649494931;
			6'd52: w = 40'h01017F0101; 6'd53: w = 40'h3F4040403F;
			6'd54: w = 40'h1F2040201F; 6'd55: w = 40'h7F2018207F;
			6'd56: w = 40'h6314081463; 6'd57: w = 40'h0304780403;
			6'd58: w = 40'h6151494543;
			default: w = 40'h0000000000;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/tpfb_front.sv =====
`include "assert_macros.svh"

module tpfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic signed [8:0] x_pos,
	input  logic signed [7:0] y_pos,
	input  logic              pixel_on,
	input  logic [7:0]        char_code,
	input  logic [9:0]        byte_addr,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output tpfb_pkg::cmd_t    cmd
);

	tpfb_pkg::cmd_t fifo_q [2];
	tpfb_pkg::cmd_t incoming;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           code_ok;

	assign do_push = push && !full;
	assign full = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = fifo_q[rd_ptr_q];

	// Codes outside the font map onto the space glyph.
	assign code_ok = (char_code >= 8'(tpfb_pkg::FIRST_CODE))
		&& (char_code <= 8'(tpfb_pkg::LAST_CODE));

	always_comb begin
		incoming.op = tpfb_pkg::req_t'(req_type);
		incoming.x = x_pos;
		incoming.y = y_pos;
		incoming.lit = (req_type == tpfb_pkg::REQ_CHAR) ? 1'b1 : pixel_on;
		incoming.sel = code_ok ? 6'(char_code - 8'(tpfb_pkg::FIRST_CODE)) : 6'd0;
		incoming.addr = byte_addr;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(cmd_pop);
		end
	end

	`FB_ASSERT(a_count_max, clk, arst_n, count_q != 2'd3, "command queue overflow")
	`FB_ASSERT(a_pop_nonempty, clk, arst_n, !cmd_pop || cmd_valid, "pop from empty queue")
	`FB_ASSERT_NEXT(a_push_grows, clk, arst_n, do_push && !cmd_pop,
		count_q == $past(count_q) + 2'd1, "transfer in did not grow the queue")

endmodule

// ===== rtl/tpfb_back.sv =====
`include "assert_macros.svh"

module tpfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  tpfb_pkg::cmd_t cmd,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     read_data
);

	localparam int AW = tpfb_pkg::MEM_AW;

	logic [7:0] mem [tpfb_pkg::STORE_BYTES];

	tpfb_pkg::state_t state_q, state_d;
	tpfb_pkg::cmd_t   cmd_q;
	logic             init_q;
	logic [AW-1:0]    clr_addr_q;
	logic [3:0]       step_q;
	logic [AW-1:0]    tgt_addr_q;
	logic [7:0]       tgt_mask_q;
	logic [7:0]       rdata_q;
	logic             res_valid_q;
	logic [7:0]       res_data_q;

	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [7:0]       mem_wd;
	logic             mem_re;
	logic [AW-1:0]    mem_ra;
	logic             res_load;
	logic             slot_free;
	logic             clr_last;
	logic             step_last;

	logic [2:0]                   col;
	logic [39:0]                  gword;
	logic [6:0]                   pattern;
	logic [15:0]                  shifted;
	logic [7:0]                   bits;
	logic signed [7:0]            band;
	logic signed [tpfb_pkg::XC_W-1:0] xcol;
	logic [7:0]                   mask;
	logic                         tgt_ok;
	logic [AW-1:0]                tgt_addr;
	logic                         read_ok;

	assign slot_free = !res_valid_q || pop;
	assign clr_last = (clr_addr_q == AW'(tpfb_pkg::STORE_BYTES - 1));
	assign step_last = (cmd_q.op == tpfb_pkg::REQ_PIXEL) ? (step_q == 4'd1) : (step_q == 4'd9);
	assign read_ok = (int'(cmd_q.addr) < tpfb_pkg::STORE_BYTES);

	// Each step covers one store byte: the glyph column, upper or lower band.
	always_comb begin
		col = step_q[3:1];
		gword = tpfb_pkg::glyph_word(cmd_q.sel);
		pattern = (cmd_q.op == tpfb_pkg::REQ_PIXEL) ? 7'd1 : gword[38 - 8 * col -: 7];
		shifted = {9'd0, pattern} << cmd_q.y[2:0];
		bits = step_q[0] ? shifted[15:8] : shifted[7:0];
		band = {{3{cmd_q.y[7]}}, cmd_q.y[7:3]} + 8'(step_q[0]);
		xcol = {{(tpfb_pkg::XC_W - 9){cmd_q.x[8]}}, cmd_q.x} + tpfb_pkg::XC_W'(col);
		mask = bits & ((band == tpfb_pkg::BANDS_S - 8'sd1) ? tpfb_pkg::LAST_ROW_MASK : 8'hFF);
		tgt_ok = (band >= 8'sd0) && (band < tpfb_pkg::BANDS_S)
			&& !xcol[tpfb_pkg::XC_W-1] && (xcol < tpfb_pkg::WIDTH_S) && (mask != 8'd0);
		tgt_addr = AW'(int'(band[6:0]) * tpfb_pkg::PANEL_WIDTH + int'(xcol[tpfb_pkg::XC_W-2:0]));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tpfb_pkg::ST_CLEAR: begin
				if (clr_last) state_d = init_q ? tpfb_pkg::ST_IDLE : tpfb_pkg::ST_RESULT;
			end
			tpfb_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						tpfb_pkg::REQ_CLEAR: state_d = tpfb_pkg::ST_CLEAR;
						tpfb_pkg::REQ_READ:  state_d = tpfb_pkg::ST_FETCH;
						tpfb_pkg::REQ_PIXEL, tpfb_pkg::REQ_CHAR: state_d = tpfb_pkg::ST_STEP;
						default: state_d = tpfb_pkg::ST_IDLE;
					endcase
				end
			end
			tpfb_pkg::ST_STEP: begin
				if (tgt_ok) state_d = tpfb_pkg::ST_WRITE;
				else if (step_last) state_d = tpfb_pkg::ST_RESULT;
			end
			tpfb_pkg::ST_WRITE: begin
				state_d = step_last ? tpfb_pkg::ST_RESULT : tpfb_pkg::ST_STEP;
			end
			tpfb_pkg::ST_FETCH: state_d = tpfb_pkg::ST_RESULT;
			tpfb_pkg::ST_RESULT: begin
				if (slot_free) state_d = tpfb_pkg::ST_IDLE;
			end
			default: state_d = tpfb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = 8'd0;
		mem_re = 1'b0;
		mem_ra = tgt_addr;
		cmd_pop = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			tpfb_pkg::ST_CLEAR: mem_we = 1'b1;
			tpfb_pkg::ST_IDLE: cmd_pop = cmd_valid;
			tpfb_pkg::ST_STEP: mem_re = tgt_ok;
			tpfb_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				mem_wa = tgt_addr_q;
				mem_wd = cmd_q.lit ? (rdata_q | tgt_mask_q) : (rdata_q & ~tgt_mask_q);
			end
			tpfb_pkg::ST_FETCH: begin
				mem_re = read_ok;
				mem_ra = AW'(cmd_q.addr);
			end
			tpfb_pkg::ST_RESULT: res_load = slot_free;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cmd_q <= cmd;
		if (state_q == tpfb_pkg::ST_STEP) begin
			tgt_addr_q <= tgt_addr;
			tgt_mask_q <= mask;
		end
		if (res_load) begin
			res_data_q <= (cmd_q.op == tpfb_pkg::REQ_READ && read_ok) ? rdata_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpfb_pkg::ST_CLEAR;
			init_q <= 1'b1;
			clr_addr_q <= '0;
			step_q <= 4'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tpfb_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
				if (clr_last) init_q <= 1'b0;
			end
			if (cmd_pop) begin
				step_q <= 4'd0;
			end else if ((state_q == tpfb_pkg::ST_STEP && !tgt_ok)
				|| state_q == tpfb_pkg::ST_WRITE) begin
				step_q <= step_q + 4'd1;
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (pop) res_valid_q <= 1'b0;
		end
	end

	assign empty = !res_valid_q;
	assign read_data = res_data_q;

	`FB_ASSERT(a_no_write_idle, clk, arst_n,
		!(state_q == tpfb_pkg::ST_IDLE && mem_we), "store written while idle")
	`FB_ASSERT(a_take_idle, clk, arst_n,
		!cmd_pop || (state_q == tpfb_pkg::ST_IDLE), "command taken while busy")
	`FB_ASSERT(a_load_free, clk, arst_n,
		!res_load || slot_free, "result overwrote a waiting transfer")
	`FB_ASSERT(a_write_after_read, clk, arst_n,
		state_q != tpfb_pkg::ST_WRITE || $past(mem_re), "write without a preceding read")

endmodule

// ===== rtl/text_pixel_framebuffer.sv =====
// One-bit 128x64 frame store kept as vertical bytes, fed requests through a
// push/full queue and giving one result per request through an empty/pop
// queue. After reset the store is zeroed by a pass over all 1024 bytes during which
// no request is taken (requests may still be queued, two deep). Requests are
// served one at a time by a read-modify-write unit on a single-port store: a
// read fetches one byte; a pixel visits two byte slots, a character ten (five
// columns, upper and lower band), reading then writing each touched byte; a
// clear zeroes every byte. read_data is the stored byte for reads, else zero.
module text_pixel_framebuffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        req_type,
	input  logic signed [8:0] x_pos,
	input  logic signed [7:0] y_pos,
	input  logic              pixel_on,
	input  logic [7:0]        char_code,
	input  logic [9:0]        byte_addr,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        read_data
);

	logic           cmd_valid;
	logic           cmd_pop;
	tpfb_pkg::cmd_t cmd;

	tpfb_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .x_pos(x_pos), .y_pos(y_pos), .pixel_on(pixel_on),
		.char_code(char_code), .byte_addr(byte_addr),
		.cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
	);

	tpfb_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.cmd(cmd), .empty(empty), .pop(pop), .read_data(read_data)
	);

endmodule

// ===== verif/text_pixel_framebuffer_tb.sv =====
`timescale 1ns / 100ps

module text_pixel_framebuffer_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int HOLD_CYCLES = 600;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [1:0]        req_type;
	logic signed [8:0] x_pos;
	logic signed [7:0] y_pos;
	logic              pixel_on;
	logic [7:0]        char_code;
	logic [9:0]        byte_addr;
	logic              empty;
	logic              pop;
	logic [7:0]        read_data;

	text_pixel_framebuffer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .x_pos(x_pos), .y_pos(y_pos),
		.pixel_on(pixel_on), .char_code(char_code), .byte_addr(byte_addr),
		.empty(empty), .pop(pop), .read_data(read_data)
	);

	typedef struct {
		tpfb_pkg::req_t    op;
		logic signed [8:0] x;
		logic signed [7:0] y;
		logic              lit;
		logic [7:0]        code;
		logic [9:0]        addr;
		bit                known;
		logic [7:0]        data;
	} request_t;

	// Predicted frame store and the queue of expected read_data values.
	logic [7:0] shadow_store [tpfb_pkg::STORE_BYTES];
	logic [7:0] expected_data [$];
	int         fail_count = 0;
	int         cycle_count = 0;
	bit         drain_phase = 0;
	bit         hold_long = 0;
	bit         stim_done = 0;

	// Font shapes, five columns per code, row r in bit r.
	logic [7:0] font_cols [59][5] = '{
		'{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
		'{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
		'{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
		'{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
		'{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
		'{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
		'{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
		'{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
		'{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
		'{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
		'{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
		'{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
		'{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
		'{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
		'{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
		'{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
		'{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
		'{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
		'{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
		'{8'h7F,8'h09,8'h09,8'h01,8'h01}, '{8'h3E,8'h41,8'h41,8'h51,8'h32},
		'{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
		'{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
		'{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
		'{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
		'{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
		'{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
		'{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
		'{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
		'{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
		'{8'h61,8'h51,8'h49,8'h45,8'h43}
	};

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void plot_shadow(int px, int py, logic lit);
		int idx;
		if (px < 0 || px >= tpfb_pkg::PANEL_WIDTH || py < 0 || py >= tpfb_pkg::PANEL_HEIGHT)
			return;
		idx = (py / 8) * tpfb_pkg::PANEL_WIDTH + px;
		shadow_store[idx][py % 8] = lit;
	endfunction

	// Applies one request to the shadow store and returns its read_data.
	function automatic logic [7:0] serve_request(request_t rq);
		int sel;
		logic [7:0] data;
		data = 8'h00;
		case (rq.op)
			tpfb_pkg::REQ_CLEAR: begin
				foreach (shadow_store[i])
					shadow_store[i] = 8'h00;
			end
			tpfb_pkg::REQ_PIXEL: plot_shadow(int'(rq.x), int'(rq.y), rq.lit);
			tpfb_pkg::REQ_CHAR: begin
				sel = (rq.code >= tpfb_pkg::FIRST_CODE && rq.code <= tpfb_pkg::LAST_CODE) ?
					int'(rq.code) - tpfb_pkg::FIRST_CODE : 0;
				for (int c = 0; c < 5; c++)
					for (int r = 0; r < 7; r++)
						if (font_cols[sel][c][r])
							plot_shadow(int'(rq.x) + c, int'(rq.y) + r, 1'b1);
			end
			default: begin
				if (rq.addr < tpfb_pkg::STORE_BYTES)
					data = shadow_store[rq.addr];
			end
		endcase
		return data;
	endfunction

	function automatic request_t make_req(tpfb_pkg::req_t op, int x, int y, logic lit,
			int code, int addr);
		request_t rq;
		rq.op = op;
		rq.x = 9'(x);
		rq.y = 8'(y);
		rq.lit = lit;
		rq.code = 8'(code);
		rq.addr = 10'(addr);
		rq.known = 1'b0;
		rq.data = 8'h00;
		return rq;
	endfunction

	function automatic request_t with_data(request_t rq, logic [7:0] d);
		rq.known = 1'b1;
		rq.data = d;
		return rq;
	endfunction

	// Mostly on-panel requests; some land far off or straddle the edges.
	function automatic request_t random_req();
		request_t rq;
		int pick;
		pick = $urandom_range(0, 99);
		rq = make_req(tpfb_pkg::REQ_READ, 0, 0, 1'b0, 0, 0);
		rq.lit = 1'($urandom);
		rq.code = 8'($urandom);
		if ($urandom_range(0, 3) != 0)
			rq.code = 8'($urandom_range(tpfb_pkg::FIRST_CODE, tpfb_pkg::LAST_CODE));
		if ($urandom_range(0, 4) == 0) begin
			rq.x = 9'($urandom);
			rq.y = 8'($urandom);
		end else begin
			rq.x = 9'($urandom_range(0, tpfb_pkg::PANEL_WIDTH + 4) - 5);
			rq.y = 8'($urandom_range(0, tpfb_pkg::PANEL_HEIGHT + 6) - 7);
		end
		rq.addr = ($urandom_range(0, 9) == 0) ? 10'($urandom) :
			10'($urandom_range(0, 1023));
		if (pick == 0)
			rq.op = tpfb_pkg::REQ_CLEAR;
		else if (pick < 30)
			rq.op = tpfb_pkg::REQ_PIXEL;
		else if (pick < 55)
			rq.op = tpfb_pkg::REQ_CHAR;
		else
			rq.op = tpfb_pkg::REQ_READ;
		return rq;
	endfunction

	task automatic send_req(request_t rq);
		logic [7:0] predicted;
		if (!drain_phase && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= rq.op;
		x_pos <= rq.x;
		y_pos <= rq.y;
		pixel_on <= rq.lit;
		char_code <= rq.code;
		byte_addr <= rq.addr;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predicted = serve_request(rq);
		if (rq.known && predicted !== rq.data) begin
			$error("table row read_data: expected %0h, predicted %0h", rq.data, predicted);
			fail_count++;
		end
		expected_data.push_back(predicted);
	endtask

	request_t directed_rows [$];

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		req_type = tpfb_pkg::REQ_CLEAR;
		x_pos = '0;
		y_pos = '0;
		pixel_on = 1'b0;
		char_code = '0;
		byte_addr = '0;
		foreach (shadow_store[i])
			shadow_store[i] = 8'h00;

		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 0), 8'h00));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, -1, -1, 1, 255, 1023),
			8'h00));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_PIXEL, 0, 0, 1, 0, 0), 8'h00));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 0), 8'h01));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_PIXEL, 127, 63, 1, 0, 0));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 1023),
			8'h80));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_PIXEL, 0, 0, 0, 0, 0));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 0), 8'h00));
		// Off-panel pixels are dropped.
		directed_rows.push_back(make_req(tpfb_pkg::REQ_PIXEL, -256, -128, 1, 0, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_PIXEL, 255, 127, 1, 0, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_PIXEL, 128, 64, 1, 0, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_CHAR, 10, 0, 0, 65, 0));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 10), 8'h7E));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_CHAR, 20, 0, 0, 200, 0));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 20), 8'h00));
		// Glyphs straddling the two corners, and one split across two bands.
		directed_rows.push_back(make_req(tpfb_pkg::REQ_CHAR, -2, -3, 0, 90, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_CHAR, 124, 60, 0, 35, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_CHAR, 40, 5, 0, 56, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 40));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 168));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 0));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 1020));
		directed_rows.push_back(make_req(tpfb_pkg::REQ_CLEAR, 0, 0, 0, 0, 0));
		directed_rows.push_back(with_data(make_req(tpfb_pkg::REQ_READ, 0, 0, 0, 0, 40), 8'h00));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_req(directed_rows[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				hold_long = 1'b1;
			if (n == RANDOM_ITEMS - 150)
				drain_phase = 1'b1;
			send_req(random_req());
		end
		push <= 1'b0;
		stim_done = 1'b1;
	end

	// Result side: random stalls, one long hold-off while the sender keeps going.
	initial begin
		int hold_cycles;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				pop <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < HOLD_CYCLES) begin
					@(posedge clk);
					hold_cycles++;
				end
				hold_long = 1'b0;
			end
			if (!drain_phase && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_data.size() == 0) begin
				$error("read_data: expected none, actual %0h", read_data);
				fail_count++;
			end else if (read_data !== expected_data[0]) begin
				$error("read_data: expected %0h, actual %0h", expected_data[0], read_data);
				fail_count++;
				void'(expected_data.pop_front());
			end else begin
				void'(expected_data.pop_front());
			end
		end
	end

	initial begin
		wait (stim_done);
		while (expected_data.size() != 0 && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && expected_data.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tpfb_pkg.sv
rtl/tpfb_front.sv
rtl/tpfb_back.sv
rtl/text_pixel_framebuffer.sv
verif/text_pixel_framebuffer_tb.sv
